@@ src/ppr_pkg.sv @@
// Shared types and constants for the packed pixel to RGB24 converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PIX_W    = 3 * BYTE_W;
    localparam int unsigned IN_W     = 4 * BYTE_W;
    localparam int unsigned OUT_W    = 2 * PIX_W;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned APB_W    = 32;
    localparam int unsigned SUM_W    = 11;

    typedef enum logic [1:0] {
        FMT_YUYV   = 2'd0,
        FMT_YVYU   = 2'd1,
        FMT_UYVY   = 2'd2,
        FMT_RGB565 = 2'd3
    } t_fmt;

    // Register index taken from paddr[2]
    typedef enum logic {
        REG_FORMAT = 1'b0,
        REG_BGR    = 1'b1
    } t_reg;

    typedef struct packed {
        logic signed [9:0] badd;
        logic signed [8:0] gsub;
        logic signed [8:0] radd;
    } t_chroma;

endpackage

`default_nettype wire

@@ src/ppr_chroma.sv @@
// Source word unpacking and shared chroma offset terms for both lanes.
// Depends on ppr_pkg.
`default_nettype none

module ppr_chroma
    import ppr_pkg::*;
(
    input  wire t_fmt              i_fmt,
    input  wire logic [IN_W-1:0]   i_word,
    output t_chroma                o_chroma,
    output logic [BYTE_W-1:0]      o_y0,
    output logic [BYTE_W-1:0]      o_y1
);

    logic [BYTE_W-1:0] b0, b1, b2, b3;
    logic [BYTE_W-1:0] u, v;
    logic signed [7:0]  d, e;
    logic signed [15:0] d129;
    logic signed [11:0] gmix;
    logic signed [9:0]  e3;

    assign b0 = i_word[7:0];
    assign b1 = i_word[15:8];
    assign b2 = i_word[23:16];
    assign b3 = i_word[31:24];

    always_comb begin
        case (i_fmt)
            FMT_YVYU: begin
                o_y0 = b0; v = b1; o_y1 = b2; u = b3;
            end
            FMT_UYVY: begin
                u = b0; o_y0 = b1; v = b2; o_y1 = b3;
            end
            default: begin
                o_y0 = b0; u = b1; o_y1 = b2; v = b3;
            end
        endcase
    end

    // value minus the chroma bias
    assign d = {~u[7], u[6:0]};
    assign e = {~v[7], v[6:0]};

    assign d129 = (16'(d) <<< 7) + 16'(d);
    assign gmix = (12'(d) <<< 1) + 12'(d) + (12'(e) <<< 2) + (12'(e) <<< 1);
    assign e3   = (10'(e) <<< 1) + 10'(e);

    assign o_chroma.badd = 10'(d129 >>> 6);
    assign o_chroma.gsub = 9'(gmix >>> 3);
    assign o_chroma.radd = 9'(e3 >>> 1);

endmodule

`default_nettype wire

@@ src/ppr_lane.sv @@
// One pixel lane: YUV add and clip or RGB565 expansion, then channel order.
// Depends on ppr_pkg.
`default_nettype none

module ppr_lane
    import ppr_pkg::*;
(
    input  wire t_fmt              i_fmt,
    input  wire logic              i_bgr,
    input  wire t_chroma           i_chroma,
    input  wire logic [BYTE_W-1:0] i_y,
    input  wire logic [BYTE_W-1:0] i_lo,
    input  wire logic [BYTE_W-1:0] i_hi,
    output logic [PIX_W-1:0]       o_pix
);

    logic signed [SUM_W-1:0] y_s, r_sum, g_sum, b_sum;
    logic [BYTE_W-1:0] r_c, g_c, b_c;
    logic [BYTE_W-1:0] red, green, blue;

    function automatic logic [BYTE_W-1:0] clip8(input logic signed [SUM_W-1:0] x);
        logic [BYTE_W-1:0] res;
        if (x[SUM_W-1]) begin
            res = '0;
        end else if (x[SUM_W-2:BYTE_W] != '0) begin
            res = '1;
        end else begin
            res = x[BYTE_W-1:0];
        end
        return res;
    endfunction

    assign y_s   = signed'({{(SUM_W-BYTE_W){1'b0}}, i_y});
    assign r_sum = y_s + SUM_W'(i_chroma.radd);
    assign g_sum = y_s - SUM_W'(i_chroma.gsub);
    assign b_sum = y_s + SUM_W'(i_chroma.badd);

    assign r_c = clip8(r_sum);
    assign g_c = clip8(g_sum);
    assign b_c = clip8(b_sum);

    always_comb begin
        if (i_fmt == FMT_RGB565) begin
            red   = {i_hi[7:3], 3'b000};
            green = {i_hi[2:0], i_lo[7:5], 2'b00};
            blue  = {i_lo[4:0], 3'b000};
        end else begin
            red   = r_c;
            green = g_c;
            blue  = b_c;
        end
    end

    assign o_pix = i_bgr ? {red, green, blue} : {blue, green, red};

endmodule

`default_nettype wire

@@ src/packed_pixel_to_rgb24_core.sv @@
// Packed pixel to RGB24 converter top level: config registers, two lanes,
// output register. Depends on ppr_pkg, ppr_chroma, ppr_lane.
// Output valid is registered and rises in the cycle after an input transfer.
// Throughput: one source word per cycle; the single output register stage
// accepts a new word whenever it is empty or being drained.
// Reset: synchronous, active low; clears format and order registers and output valid.
`default_nettype none

module packed_pixel_to_rgb24_core
    import ppr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]       prdata,
    output logic                   pready,
    // input stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_W-1:0]   i_s_tdata,   // byte0, byte1, byte2, byte3
    input  wire logic              i_s_tlast,   // end_of_frame
    // output stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_W-1:0]       o_m_tdata,   // pix0_first, pix0_green, pix0_third,
                                                // pix1_first, pix1_green, pix1_third
    output logic                   o_m_tlast    // frame_done
);

    t_fmt              r_fmt, n_fmt;
    logic              r_bgr, n_bgr;
    logic              r_valid, n_valid;
    logic [OUT_W-1:0]  r_data;
    logic              r_last;
    logic              cfg_wr;
    logic              s_xfer;
    t_chroma           chroma;
    logic [BYTE_W-1:0] y0, y1;
    logic [PIX_W-1:0]  pix0, pix1;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        n_fmt = r_fmt;
        n_bgr = r_bgr;
        if (cfg_wr) begin
            case (t_reg'(paddr[2]))
                REG_FORMAT: n_fmt = t_fmt'(pwdata[1:0]);
                REG_BGR:    n_bgr = pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[2]))
            REG_BGR: prdata = {{(APB_W-1){1'b0}}, r_bgr};
            default: prdata = {{(APB_W-2){1'b0}}, r_fmt};
        endcase
    end

    ppr_chroma u_chroma (
        .i_fmt    (r_fmt),
        .i_word   (i_s_tdata),
        .o_chroma (chroma),
        .o_y0     (y0),
        .o_y1     (y1)
    );

    ppr_lane u_lane0 (
        .i_fmt    (r_fmt),
        .i_bgr    (r_bgr),
        .i_chroma (chroma),
        .i_y      (y0),
        .i_lo     (i_s_tdata[7:0]),
        .i_hi     (i_s_tdata[15:8]),
        .o_pix    (pix0)
    );

    ppr_lane u_lane1 (
        .i_fmt    (r_fmt),
        .i_bgr    (r_bgr),
        .i_chroma (chroma),
        .i_y      (y1),
        .i_lo     (i_s_tdata[23:16]),
        .i_hi     (i_s_tdata[31:24]),
        .o_pix    (pix1)
    );

    assign o_s_tready = ~r_valid | i_m_tready;
    assign s_xfer     = i_s_tvalid & o_s_tready;

    always_comb begin
        n_valid = r_valid;
        if (o_s_tready) begin
            n_valid = i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_YUYV;
            r_bgr   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_fmt   <= n_fmt;
            r_bgr   <= n_bgr;
            r_valid <= n_valid;
        end
    end

    // merge lane results into the output word
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_data <= {pix1, pix0};
            r_last <= i_s_tlast;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire
